// File: sv/fpc_pkg.sv
// ---------------------------------------------------------------------------
// fpc_pkg
// Shared types and codes for the page cache directory.
// ---------------------------------------------------------------------------
`default_nettype none

package fpc_pkg;

    localparam int SLOT_W  = 4;
    localparam int BLK_W   = 23;
    localparam int OFF_W   = 12;
    localparam int RWX_W   = 3;
    localparam int REQ_W   = 3;
    localparam int KIND_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 11;
    localparam int LIM_W   = 21;

    localparam logic [BLK_W-1:0] BLOCK_MAX   = 23'h7fffff;
    localparam logic [BLK_W-1:0] PAGE_BLOCKS = 23'd8;

    localparam logic [REQ_W-1:0] REQ_READ  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FETCH = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WRITE = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SETP  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GETP  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_LOAD  = 3'd5;

    localparam logic [KIND_W-1:0] KIND_RESULT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WBACK  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FFILE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FTEMP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FZERO  = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_PERM  = 2'd2;

    localparam logic [RWX_W-1:0] NEED_READ  = 3'b001;
    localparam logic [RWX_W-1:0] NEED_WRITE = 3'b010;
    localparam logic [RWX_W-1:0] NEED_EXEC  = 3'b100;

    typedef struct packed {
        logic [BLK_W-1:0]  file_block;
        logic [RWX_W-1:0]  rwx;
        logic              modified;
        logic              has_data;
        logic [SLOT_W-1:0] resident;
    } pte_t;

endpackage

`default_nettype wire

// File: sv/fpc_ram.sv
// ---------------------------------------------------------------------------
// fpc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module fpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/fifo_page_cache_directory.sv
// ---------------------------------------------------------------------------
// fifo_page_cache_directory
// Page table and slot directory of a small page cache with FIFO replacement.
//
// Requests arrive on the s_axis channel (tuser = request type). Each request
// gives one or more result transactions on m_axis; tlast marks the final one.
// Write-back and fill commands come first, the access result last.
// A recent-page hit skips the page-table read. A miss brings in one or
// two pages through the page-table RAM's single read port: each eviction
// reads the old owner and then the new page. A miss on a page whose next
// page is in range also looks that page up first.
// One request is in flight at a time; s_axis_tready is high only between
// requests.
// After reset the page-table RAM is cleared one entry per cycle, all
// NUM_PAGES entries, with s_axis_tready low; cfg writes are taken at any time.
// When m_axis_tready is low the block holds the pending result in its
// output register and stalls until it is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module fifo_page_cache_directory #(
    parameter int NUM_PAGES = 1024,
    parameter int NUM_SLOTS = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[31:0], rwx[34:32], file_block[57:35], has_data[58], zero pad
    input  wire logic [63:0] s_axis_tdata,
    // req_type[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], slot[5:2], page_offset[17:6], block_addr[40:18],
    // rwx_out[43:41], zero pad
    output logic [47:0]      m_axis_tdata,
    // result_kind[2:0]
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    import fpc_pkg::*;

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int SIW = $clog2(NUM_SLOTS);
    localparam logic [LIM_W-1:0]  NP_L      = LIM_W'(NUM_PAGES);
    localparam logic [PW-1:0]     LAST_PAGE = PW'(NUM_PAGES - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LOOK  = 4'd2;
    localparam logic [3:0] S_NXT   = 4'd3;
    localparam logic [3:0] S_BV    = 4'd4;
    localparam logic [3:0] S_BOLD  = 4'd5;
    localparam logic [3:0] S_BFILL = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [PW-1:0]     clr_reg, clr_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [PW-1:0]     page_reg, page_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [RWX_W-1:0]  rwx_reg, rwx_next;
    logic [BLK_W-1:0]  fblk_reg, fblk_next;
    logic              hd_reg, hd_next;
    logic [PW-1:0]     target_reg, target_next;
    logic              second_reg, second_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] victim_reg, victim_next;
    logic [PW-1:0]     recent_page_reg, recent_page_next;
    logic              recent_valid_reg, recent_valid_next;
    logic [SLOT_W-1:0] recent_slot_reg, recent_slot_next;
    logic [BLK_W-1:0]  temp_reg, temp_next;
    logic [CFG_W-1:0]  piu_reg, piu_next;
    logic [STAT_W-1:0] fin_status_reg, fin_status_next;
    logic [OFF_W-1:0]  fin_off_reg, fin_off_next;
    logic [RWX_W-1:0]  fin_rwx_reg, fin_rwx_next;

    logic              mv_reg;
    logic [KIND_W-1:0] mk_reg;
    logic [STAT_W-1:0] ms_reg;
    logic [SLOT_W-1:0] mslot_reg;
    logic [OFF_W-1:0]  moff_reg;
    logic [BLK_W-1:0]  mblk_reg;
    logic [RWX_W-1:0]  mrwx_reg;
    logic              mlast_reg;

    logic [PW-1:0]     owner_reg [NUM_SLOTS];
    logic              owner_valid_reg [NUM_SLOTS];
    logic [RWX_W-1:0]  perm_reg [NUM_SLOTS];
    logic              dirty_reg [NUM_SLOTS];

    logic              ram_we;
    logic [PW-1:0]     ram_waddr, ram_raddr;
    pte_t              ram_wdata, rd_q;
    logic [31:0]       rd_raw;

    logic              emit;
    logic [KIND_W-1:0] e_kind;
    logic [STAT_W-1:0] e_status;
    logic [SLOT_W-1:0] e_slot;
    logic [OFF_W-1:0]  e_off;
    logic [BLK_W-1:0]  e_blk;
    logic [RWX_W-1:0]  e_rwx;
    logic              e_last;

    logic              fill_we, dirty_we;
    logic              out_free, in_acc;
    logic [LIM_W-1:0]  limit, in_page_l, nxt_page_l;
    logic [19:0]       in_page;
    logic [REQ_W-1:0]  in_req;
    logic              in_range, in_access;
    logic [SIW-1:0]    vi, si;
    logic [BLK_W-1:0]  wb_blk;
    logic [RWX_W-1:0]  need;
    logic              perm_ok;

    assign rd_q = pte_t'(rd_raw);

    fpc_ram #(.WIDTH(32), .DEPTH(NUM_PAGES)) u_ptab (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_raw)
    );

    assign out_free   = !mv_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign in_page    = s_axis_tdata[31:12];
    assign in_req     = s_axis_tuser;
    assign limit      = ({10'd0, piu_reg} < NP_L) ? {10'd0, piu_reg} : NP_L;
    assign in_page_l  = {1'b0, in_page};
    assign in_range   = in_page_l < limit;
    assign in_access  = in_req <= REQ_WRITE;
    assign nxt_page_l = LIM_W'(page_reg) + LIM_W'(1);
    assign vi         = victim_reg[SIW-1:0];
    assign si         = slot_reg[SIW-1:0];
    assign wb_blk     = rd_q.modified ? rd_q.file_block : temp_reg;

    always_comb begin
        unique case (req_reg)
            REQ_READ:  need = NEED_READ;
            REQ_FETCH: need = NEED_EXEC;
            default:   need = NEED_WRITE;
        endcase
    end
    assign perm_ok = |(perm_reg[si] & need);

    always_comb begin
        state_next        = state_reg;
        clr_next          = clr_reg;
        req_next          = req_reg;
        page_next         = page_reg;
        off_next          = off_reg;
        rwx_next          = rwx_reg;
        fblk_next         = fblk_reg;
        hd_next           = hd_reg;
        target_next       = target_reg;
        second_next       = second_reg;
        slot_next         = slot_reg;
        victim_next       = victim_reg;
        recent_page_next  = recent_page_reg;
        recent_valid_next = recent_valid_reg;
        recent_slot_next  = recent_slot_reg;
        temp_next         = temp_reg;
        piu_next          = cfg_wr_en ? cfg_wr_data : piu_reg;
        fin_status_next   = fin_status_reg;
        fin_off_next      = fin_off_reg;
        fin_rwx_next      = fin_rwx_reg;

        ram_we    = 1'b0;
        ram_waddr = page_reg;
        ram_wdata = rd_q;
        ram_raddr = in_page[PW-1:0];

        emit     = 1'b0;
        e_kind   = KIND_RESULT;
        e_status = ST_OK;
        e_slot   = '0;
        e_off    = '0;
        e_blk    = '0;
        e_rwx    = '0;
        e_last   = 1'b0;
        fill_we  = 1'b0;
        dirty_we = 1'b0;

        unique case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + PW'(1);
                if (clr_reg == LAST_PAGE) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    req_next        = in_req;
                    page_next       = in_page[PW-1:0];
                    off_next        = s_axis_tdata[11:0];
                    rwx_next        = s_axis_tdata[34:32];
                    fblk_next       = s_axis_tdata[57:35];
                    hd_next         = s_axis_tdata[58];
                    fin_status_next = ST_OK;
                    fin_off_next    = '0;
                    fin_rwx_next    = '0;
                    if (in_req > REQ_LOAD) begin
                        state_next = S_FINAL;
                    end else if (!in_range) begin
                        fin_status_next = ST_RANGE;
                        fin_off_next    = in_access ? s_axis_tdata[11:0] : '0;
                        state_next      = S_FINAL;
                    end else if (in_access && recent_valid_reg &&
                                 recent_page_reg == in_page[PW-1:0]) begin
                        slot_next  = recent_slot_reg;
                        state_next = S_ACC;
                    end else begin
                        state_next = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                ram_raddr = nxt_page_l[PW-1:0];
                unique case (req_reg)
                    REQ_SETP: begin
                        ram_we        = 1'b1;
                        ram_wdata.rwx = rwx_reg;
                        state_next    = S_FINAL;
                    end
                    REQ_GETP: begin
                        fin_rwx_next = rd_q.rwx;
                        state_next   = S_FINAL;
                    end
                    REQ_LOAD: begin
                        ram_we               = 1'b1;
                        ram_wdata.file_block = fblk_reg;
                        ram_wdata.rwx        = rwx_reg;
                        ram_wdata.modified   = 1'b0;
                        ram_wdata.has_data   = hd_reg;
                        state_next           = S_FINAL;
                    end
                    default: begin
                        if (rd_q.resident != '0) begin
                            slot_next         = rd_q.resident - SLOT_W'(1);
                            recent_page_next  = page_reg;
                            recent_slot_next  = rd_q.resident - SLOT_W'(1);
                            recent_valid_next = 1'b1;
                            state_next        = S_ACC;
                        end else if (nxt_page_l < limit) begin
                            state_next = S_NXT;
                        end else begin
                            target_next = page_reg;
                            second_next = 1'b0;
                            state_next  = S_BV;
                        end
                    end
                endcase
            end
            S_NXT: begin
                if (rd_q.resident == '0) begin
                    target_next = nxt_page_l[PW-1:0];
                    second_next = 1'b1;
                end else begin
                    target_next = page_reg;
                    second_next = 1'b0;
                end
                state_next = S_BV;
            end
            S_BV: begin
                if (recent_valid_reg && recent_slot_reg == victim_reg) begin
                    recent_valid_next = 1'b0;
                end
                if (owner_valid_reg[vi]) begin
                    ram_raddr  = owner_reg[vi];
                    state_next = S_BOLD;
                end else begin
                    ram_raddr  = target_reg;
                    state_next = S_BFILL;
                end
            end
            S_BOLD: begin
                ram_raddr = owner_reg[vi];
                ram_waddr = owner_reg[vi];
                if (!dirty_reg[vi] || out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata.resident = '0;
                    ram_raddr          = target_reg;
                    state_next         = S_BFILL;
                    if (dirty_reg[vi]) begin
                        ram_wdata.has_data   = 1'b1;
                        ram_wdata.modified   = 1'b1;
                        ram_wdata.file_block = wb_blk;
                        if (!rd_q.modified) begin
                            temp_next = (temp_reg > BLOCK_MAX - PAGE_BLOCKS) ?
                                        BLOCK_MAX : temp_reg + PAGE_BLOCKS;
                        end
                        emit   = 1'b1;
                        e_kind = KIND_WBACK;
                        e_slot = victim_reg;
                        e_blk  = wb_blk;
                    end
                end
            end
            S_BFILL: begin
                ram_raddr = target_reg;
                ram_waddr = target_reg;
                if (out_free) begin
                    ram_we             = 1'b1;
                    ram_wdata.resident = victim_reg + SLOT_W'(1);
                    fill_we            = 1'b1;
                    emit               = 1'b1;
                    e_slot             = victim_reg;
                    if (!rd_q.has_data) begin
                        e_kind = KIND_FZERO;
                    end else begin
                        e_kind = rd_q.modified ? KIND_FTEMP : KIND_FFILE;
                        e_blk  = rd_q.file_block;
                    end
                    victim_next = (victim_reg == LAST_SLOT) ? '0 : victim_reg + SLOT_W'(1);
                    if (second_reg) begin
                        target_next = page_reg;
                        second_next = 1'b0;
                        state_next  = S_BV;
                    end else begin
                        slot_next  = victim_reg;
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_status   = perm_ok ? ST_OK : ST_PERM;
                    e_slot     = slot_reg;
                    e_off      = off_reg;
                    e_last     = 1'b1;
                    dirty_we   = perm_ok && (req_reg == REQ_WRITE);
                    state_next = S_IDLE;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    emit       = 1'b1;
                    e_status   = fin_status_reg;
                    e_off      = fin_off_reg;
                    e_rwx      = fin_rwx_reg;
                    e_last     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLR;
            clr_reg          <= '0;
            victim_reg       <= '0;
            recent_valid_reg <= 1'b0;
            recent_slot_reg  <= '0;
            temp_reg         <= '0;
            piu_reg          <= 11'd1024;
            mv_reg           <= 1'b0;
        end else begin
            state_reg        <= state_next;
            clr_reg          <= clr_next;
            victim_reg       <= victim_next;
            recent_valid_reg <= recent_valid_next;
            recent_slot_reg  <= recent_slot_next;
            temp_reg         <= temp_next;
            piu_reg          <= piu_next;
            if (emit) begin
                mv_reg <= 1'b1;
            end else if (m_axis_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg         <= req_next;
        page_reg        <= page_next;
        off_reg         <= off_next;
        rwx_reg         <= rwx_next;
        fblk_reg        <= fblk_next;
        hd_reg          <= hd_next;
        target_reg      <= target_next;
        second_reg      <= second_next;
        slot_reg        <= slot_next;
        recent_page_reg <= recent_page_next;
        fin_status_reg  <= fin_status_next;
        fin_off_reg     <= fin_off_next;
        fin_rwx_reg     <= fin_rwx_next;
        if (emit) begin
            mk_reg    <= e_kind;
            ms_reg    <= e_status;
            mslot_reg <= e_slot;
            moff_reg  <= e_off;
            mblk_reg  <= e_blk;
            mrwx_reg  <= e_rwx;
            mlast_reg <= e_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (fill_we) begin
            owner_reg[vi] <= target_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                owner_valid_reg[i] <= 1'b0;
                perm_reg[i]        <= '0;
                dirty_reg[i]       <= 1'b0;
            end
        end else begin
            if (fill_we) begin
                owner_valid_reg[vi] <= 1'b1;
                perm_reg[vi]        <= rd_q.rwx;
                dirty_reg[vi]       <= 1'b0;
            end
            if (dirty_we) begin
                dirty_reg[si] <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tuser  = mk_reg;
    assign m_axis_tlast  = mlast_reg;
    assign m_axis_tdata  = {4'd0, mrwx_reg, mblk_reg, moff_reg, mslot_reg, ms_reg};

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking testbench for the page cache directory.
//
// Requests go in on s_axis with random gaps; results are taken from m_axis
// with random stalls. A scoreboard class keeps its own page table and slot
// directory and predicts every command and access result, then compares
// them field by field in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    import fpc_pkg::*;

    localparam int N_PAGES = 1024;
    localparam int N_SLOTS = 15;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [OFF_W-1:0]  offset;
        logic [BLK_W-1:0]  blk;
        logic [RWX_W-1:0]  rwx;
        logic              last;
    } cache_result_t;

    class cache_scoreboard;
        logic [BLK_W-1:0]  pg_block [N_PAGES];
        logic [RWX_W-1:0]  pg_rwx [N_PAGES];
        bit                pg_mod [N_PAGES];
        bit                pg_data [N_PAGES];
        int                pg_res [N_PAGES];
        int                owner [N_SLOTS];
        logic [RWX_W-1:0]  perm [N_SLOTS];
        bit                dirty [N_SLOTS];
        int                victim;
        int                recent_pg;
        bit                recent_ok;
        int                recent_sl;
        logic [BLK_W-1:0]  temp_used;
        int                page_limit;
        cache_result_t     pending [$];
        int                errors;
        int                checked;

        function new();
            for (int i = 0; i < N_PAGES; i++) begin
                pg_block[i] = '0; pg_rwx[i] = '0; pg_mod[i] = 0;
                pg_data[i] = 0; pg_res[i] = 0;
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                owner[i] = -1; perm[i] = '0; dirty[i] = 0;
            end
            victim = 0; recent_pg = 0; recent_ok = 0; recent_sl = 0;
            temp_used = '0; page_limit = N_PAGES; errors = 0; checked = 0;
        endfunction

        function void set_limit(int v);
            page_limit = (v < N_PAGES) ? v : N_PAGES;
        endfunction

        function void push(logic [KIND_W-1:0] k, logic [STAT_W-1:0] st, int sl,
                           logic [OFF_W-1:0] off, logic [BLK_W-1:0] b,
                           logic [RWX_W-1:0] r);
            cache_result_t e;
            e.kind = k; e.status = st; e.slot = sl[SLOT_W-1:0]; e.offset = off;
            e.blk = b; e.rwx = r; e.last = 1'b0;
            pending.push_back(e);
        endfunction

        function void bring_in(int pg);
            int v;
            int o;
            v = victim;
            victim = (v + 1 >= N_SLOTS) ? 0 : v + 1;
            o = owner[v];
            if (o >= 0) begin
                pg_res[o] = 0;
                if (dirty[v]) begin
                    pg_data[o] = 1;
                    if (!pg_mod[o]) begin
                        pg_mod[o] = 1;
                        pg_block[o] = temp_used;
                        temp_used = (temp_used > BLOCK_MAX - PAGE_BLOCKS) ?
                                    BLOCK_MAX : temp_used + PAGE_BLOCKS;
                    end
                    push(KIND_WBACK, ST_OK, v, '0, pg_block[o], '0);
                end
            end
            if (recent_ok && recent_sl == v) recent_ok = 0;
            owner[v] = pg; perm[v] = pg_rwx[pg]; dirty[v] = 0;
            pg_res[pg] = v + 1;
            if (!pg_data[pg]) push(KIND_FZERO, ST_OK, v, '0, '0, '0);
            else push(pg_mod[pg] ? KIND_FTEMP : KIND_FFILE, ST_OK, v, '0,
                      pg_block[pg], '0);
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [31:0] addr,
                                   logic [RWX_W-1:0] rwx, logic [BLK_W-1:0] fb,
                                   bit hd);
            int pg;
            int sl;
            int n0;
            logic [RWX_W-1:0] need;
            logic [OFF_W-1:0] off;
            pg = int'(addr[31:12]);
            off = addr[11:0];
            n0 = pending.size();
            if (req > REQ_LOAD) push(KIND_RESULT, ST_OK, 0, '0, '0, '0);
            else if (pg >= page_limit)
                push(KIND_RESULT, ST_RANGE, 0, (req <= REQ_WRITE) ? off : '0, '0, '0);
            else if (req <= REQ_WRITE) begin
                need = (req == REQ_READ) ? NEED_READ :
                       (req == REQ_FETCH) ? NEED_EXEC : NEED_WRITE;
                if (recent_ok && recent_pg == pg) sl = recent_sl;
                else if (pg_res[pg] != 0) begin
                    sl = pg_res[pg] - 1;
                    recent_pg = pg; recent_sl = sl; recent_ok = 1;
                end else begin
                    if (pg + 1 < page_limit && pg_res[pg + 1] == 0) bring_in(pg + 1);
                    bring_in(pg);
                    sl = pg_res[pg] - 1;
                end
                if ((perm[sl] & need) != 0) begin
                    if (req == REQ_WRITE) dirty[sl] = 1;
                    push(KIND_RESULT, ST_OK, sl, off, '0, '0);
                end else push(KIND_RESULT, ST_PERM, sl, off, '0, '0);
            end else if (req == REQ_SETP) begin
                pg_rwx[pg] = rwx;
                push(KIND_RESULT, ST_OK, 0, '0, '0, '0);
            end else if (req == REQ_GETP) push(KIND_RESULT, ST_OK, 0, '0, '0, pg_rwx[pg]);
            else begin
                pg_block[pg] = fb; pg_rwx[pg] = rwx; pg_mod[pg] = 0; pg_data[pg] = hd;
                push(KIND_RESULT, ST_OK, 0, '0, '0, '0);
            end
            if (pending.size() > n0) pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_result(cache_result_t got);
            cache_result_t want;
            checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [47:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    cache_scoreboard sb = new();
    bit calm = 0;
    int sent = 0;

    always #6 aclk = ~aclk;

    fifo_page_cache_directory dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // result side: random stall bursts, sampled at the edge
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                cache_result_t r;
                r.kind = m_axis_tuser;
                r.status = m_axis_tdata[1:0];
                r.slot = m_axis_tdata[5:2];
                r.offset = m_axis_tdata[17:6];
                r.blk = m_axis_tdata[40:18];
                r.rwx = m_axis_tdata[43:41];
                r.last = m_axis_tlast;
                sb.check_result(r);
            end
            if (stall > 0) stall--;
            else if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 8);
            m_axis_tready <= (stall == 0);
        end
    end

    task automatic write_limit(int v);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= v[10:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.set_limit(v);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // tvalid stays up after an accepted transaction until the next call
    // replaces the data in the same step or a gap or drain drops it
    task automatic send(logic [REQ_W-1:0] req, logic [31:0] addr, logic [RWX_W-1:0] rwx,
                        logic [BLK_W-1:0] fb, bit hd);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= req;
        s_axis_tdata <= {5'b0, hd, fb, rwx, addr};
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_request(req, addr, rwx, fb, hd);
        sent++;
    endtask

    function automatic logic [31:0] page_addr(int pg);
        return {pg[19:0], 12'($urandom)};
    endfunction

    // mostly a small working set so hits, misses and evictions all occur
    task automatic random_request(int span);
        int pick;
        int pg;
        pick = $urandom_range(0, 99);
        pg = $urandom_range(0, span);
        if (pick < 3) send(REQ_W'($urandom_range(6, 7)), $urandom, 3'($urandom),
                           23'($urandom), 1'($urandom));
        else if (pick < 8) send(REQ_READ, $urandom, '0, '0, 0);
        else if (pick < 16) send(REQ_SETP, page_addr(pg), 3'($urandom), '0, 0);
        else if (pick < 22) send(REQ_GETP, page_addr(pg), '0, '0, 0);
        else if (pick < 32) send(REQ_LOAD, page_addr(pg), 3'($urandom),
                                 23'($urandom), 1'($urandom));
        else send(REQ_W'($urandom_range(0, 2)), page_addr(pg), '0, '0, 0);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        write_limit(1024);

        // directed part
        send(REQ_LOAD, 32'h0000_0000, 3'b111, 23'h7fffff, 1);
        send(REQ_LOAD, 32'h0000_1fff, 3'b001, 23'h000001, 1);
        send(REQ_READ, 32'h0000_0abc, '0, '0, 0);
        send(REQ_WRITE, 32'h0000_0fff, '0, '0, 0);
        send(REQ_FETCH, 32'h0000_0000, '0, '0, 0);
        send(REQ_WRITE, 32'h0000_1000, '0, '0, 0);
        send(REQ_SETP, 32'h0000_1000, 3'b110, '0, 0);
        send(REQ_GETP, 32'h0000_1000, '0, '0, 0);
        send(REQ_WRITE, 32'h0000_1234, '0, '0, 0);
        send(REQ_READ, 32'h003f_f000, '0, '0, 0);
        send(REQ_READ, 32'h0040_0000, '0, '0, 0);
        send(REQ_READ, 32'hffff_ffff, '0, '0, 0);
        send(3'd6, 32'h1234_5678, 3'b101, 23'h555555, 1);
        send(3'd7, 32'h0, '0, '0, 0);
        for (int i = 2; i < 20; i += 2) send(REQ_WRITE, page_addr(i), '0, '0, 0);
        send(REQ_READ, 32'h0000_0010, '0, '0, 0);

        // hold off until everything is back, then shrink the image
        drain();
        write_limit(1);
        send(REQ_READ, 32'h0000_0000, '0, '0, 0);
        send(REQ_READ, 32'h0000_1000, '0, '0, 0);
        drain();
        write_limit(0);
        send(REQ_GETP, 32'h0000_0000, '0, '0, 0);
        drain();
        write_limit(2047);

        for (int i = 0; i < 150; i++) random_request(40);
        drain();
        write_limit(37);
        for (int i = 0; i < 60; i++) random_request(45);
        drain();
        write_limit(1024);
        calm = 1;
        for (int i = 0; i < 40; i++) random_request(30);
        drain();

        $display("tb: %0d requests, %0d result transactions checked", sent, sb.checked);
        $display("tb: limits 0, 1, 37, 1024 and 2047; hits, misses, write-backs covered");
        if (sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/fpc_pkg.sv
sv/fpc_ram.sv
sv/fifo_page_cache_directory.sv
tb/sv/tb.sv
